/* hdl/assert_macros.svh */
// Assertion macros used by the checker file of the line drawer.
// No dependencies; take in with `include before use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is high
`define PLD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds during reset
`define PLD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/pld_pkg.sv */
// Shared constants of the planar line drawer: field widths, mode codes and the leftmost pixel mask.
// No dependencies.
`timescale 1ns / 1ps

package pld_pkg;

  // Field widths
  localparam int X_W     = 8;
  localparam int Y_W     = 7;
  localparam int COLOR_W = 4;
  localparam int OFF_W   = 14;
  localparam int ERR_W   = 10;

  // Command modes
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  // Leftmost pixel of a byte
  localparam logic [7:0] PIXEL_MSB = 8'h80;

endpackage

/* hdl/pld_cmd_if.sv */
// Command channel of the line drawer: start and step transactions.
// Depends on pld_pkg for field widths.
`timescale 1ns / 1ps

interface pld_cmd_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [pld_pkg::X_W-1:0]     start_x;
  logic [pld_pkg::Y_W-1:0]     start_y;
  logic [pld_pkg::X_W-1:0]     end_x;
  logic [pld_pkg::Y_W-1:0]     end_y;
  logic [pld_pkg::COLOR_W-1:0] pen_color;

  modport source (output valid, mode, start_x, start_y, end_x, end_y, pen_color,
                  input ready);
  modport sink   (input valid, mode, start_x, start_y, end_x, end_y, pen_color,
                  output ready);
endinterface

/* hdl/pld_pixel_if.sv */
// Pixel result channel of the line drawer: one write description per transaction.
// Depends on pld_pkg for field widths.
`timescale 1ns / 1ps

interface pld_pixel_if;
  logic                      valid;
  logic                      ready;
  logic                      pixel_valid;
  logic [pld_pkg::OFF_W-1:0] byte_offset;
  logic [7:0]                keep_mask;
  logic [7:0]                plane0_bits;
  logic [7:0]                plane1_bits;
  logic [7:0]                plane2_bits;
  logic [7:0]                plane3_bits;
  logic                      last_pixel;

  modport source (output valid, pixel_valid, byte_offset, keep_mask, plane0_bits,
                  plane1_bits, plane2_bits, plane3_bits, last_pixel,
                  input ready);
  modport sink   (input valid, pixel_valid, byte_offset, keep_mask, plane0_bits,
                  plane1_bits, plane2_bits, plane3_bits, last_pixel,
                  output ready);
endinterface

/* hdl/planar_line_drawer_unit.sv */
// Bresenham line engine for a four-plane, row-interleaved frame buffer.
// Depends on pld_pkg, pld_cmd_if and pld_pixel_if.
`timescale 1ns / 1ps

// The engine takes one command transaction per clock cycle unless stalled and
// gives one pixel transaction for each, in the cycle after acceptance, from an
// output register. A start command latches both endpoints and the colour and
// returns the first pixel; each step command advances the line by one pixel with
// a single error-term update. The command side stays ready while the output
// register is empty or being drained in the same cycle, so a stalled sink only
// holds off new commands once its register is full. Steps with no line in
// progress return a transaction with pixel_valid low and all other fields zero.
// The byte offset is y * 4 * ROW_BYTES + x / 8 modulo 2^14; plane p of the same
// pixel sits p * ROW_BYTES further on, which the memory side adds.
module planar_line_drawer_unit #(
  parameter int ROW_BYTES = 30
) (
  input  logic        clk,
  input  logic        rst,
  pld_cmd_if.sink     cmd,
  pld_pixel_if.source pix
);

  localparam int X_W   = pld_pkg::X_W;
  localparam int Y_W   = pld_pkg::Y_W;
  localparam int OFF_W = pld_pkg::OFF_W;
  localparam int ERR_W = pld_pkg::ERR_W;
  localparam int E2_W  = ERR_W + 1;
  localparam logic [OFF_W-1:0] ROW_STRIDE = OFF_W'(4 * ROW_BYTES);

  // Line state
  logic [X_W-1:0]               cur_x, target_x, delta_x;
  logic [Y_W-1:0]               cur_y, target_y;
  logic [X_W-1:0]               neg_delta_y;
  logic                         step_x_neg, step_y_neg;
  logic [ERR_W-1:0]             error_term;
  logic [pld_pkg::COLOR_W-1:0]  line_color;
  logic                         line_active;

  logic [X_W-1:0]               cur_x_next, target_x_next, delta_x_next;
  logic [Y_W-1:0]               cur_y_next, target_y_next;
  logic [X_W-1:0]               neg_delta_y_next;
  logic                         step_x_neg_next, step_y_neg_next;
  logic [ERR_W-1:0]             error_term_next;
  logic [pld_pkg::COLOR_W-1:0]  line_color_next;
  logic                         line_active_next;

  logic                         emit;
  logic                         is_last;
  logic [Y_W-1:0]               abs_dy;
  logic signed [E2_W-1:0]       e2;
  logic                         take_x, take_y;
  logic [7:0]                   pixel_bit;
  logic [OFF_W-1:0]             offset_calc;

  logic                         cmd_fire;

  // Output register
  logic                         out_valid;
  logic                         out_pixel_valid;
  logic [OFF_W-1:0]             out_offset;
  logic [7:0]                   out_keep;
  logic [7:0]                   out_p0, out_p1, out_p2, out_p3;
  logic                         out_last;

  // Handshake: ready whenever the output register is free or draining
  assign cmd.ready = !out_valid || pix.ready;
  assign cmd_fire  = cmd.valid && cmd.ready;

  // Step decision from the stored error term
  assign e2     = $signed({error_term, 1'b0});
  assign take_x = e2 >= $signed({{(E2_W-X_W){neg_delta_y[X_W-1]}}, neg_delta_y});
  assign take_y = e2 <= $signed({{(E2_W-X_W){1'b0}}, delta_x});

  // Next line state
  always_comb begin
    cur_x_next       = cur_x;
    cur_y_next       = cur_y;
    target_x_next    = target_x;
    target_y_next    = target_y;
    delta_x_next     = delta_x;
    neg_delta_y_next = neg_delta_y;
    step_x_neg_next  = step_x_neg;
    step_y_neg_next  = step_y_neg;
    error_term_next  = error_term;
    line_color_next  = line_color;
    abs_dy           = '0;
    emit             = 1'b0;
    if (cmd.mode == pld_pkg::MODE_START) begin
      cur_x_next       = cmd.start_x;
      cur_y_next       = cmd.start_y;
      target_x_next    = cmd.end_x;
      target_y_next    = cmd.end_y;
      delta_x_next     = (cmd.end_x > cmd.start_x) ? cmd.end_x - cmd.start_x
                                                   : cmd.start_x - cmd.end_x;
      abs_dy           = (cmd.end_y > cmd.start_y) ? cmd.end_y - cmd.start_y
                                                   : cmd.start_y - cmd.end_y;
      neg_delta_y_next = ~{1'b0, abs_dy} + X_W'(1);
      step_x_neg_next  = !(cmd.start_x < cmd.end_x);
      step_y_neg_next  = !(cmd.start_y < cmd.end_y);
      error_term_next  = {{(ERR_W-X_W){1'b0}}, delta_x_next}
                       + {{(ERR_W-X_W){neg_delta_y_next[X_W-1]}}, neg_delta_y_next};
      line_color_next  = cmd.pen_color;
      emit             = 1'b1;
    end else if (line_active) begin
      error_term_next = error_term
        + (take_x ? {{(ERR_W-X_W){neg_delta_y[X_W-1]}}, neg_delta_y} : ERR_W'(0))
        + (take_y ? {{(ERR_W-X_W){1'b0}}, delta_x} : ERR_W'(0));
      if (take_x) begin
        cur_x_next = step_x_neg ? cur_x - X_W'(1) : cur_x + X_W'(1);
      end
      if (take_y) begin
        cur_y_next = step_y_neg ? cur_y - Y_W'(1) : cur_y + Y_W'(1);
      end
      emit = 1'b1;
    end
  end

  assign is_last          = (cur_x_next == target_x_next) && (cur_y_next == target_y_next);
  assign line_active_next = emit ? !is_last : line_active;

  // Pixel address and masks
  assign pixel_bit   = pld_pkg::PIXEL_MSB >> cur_x_next[2:0];
  assign offset_calc = OFF_W'({{(OFF_W-Y_W){1'b0}}, cur_y_next} * ROW_STRIDE)
                     + OFF_W'(cur_x_next[X_W-1:3]);

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      target_x    <= '0;
      target_y    <= '0;
      delta_x     <= '0;
      neg_delta_y <= '0;
      step_x_neg  <= 1'b0;
      step_y_neg  <= 1'b0;
      error_term  <= '0;
      line_color  <= '0;
      line_active <= 1'b0;
    end else if (cmd_fire) begin
      cur_x       <= cur_x_next;
      cur_y       <= cur_y_next;
      target_x    <= target_x_next;
      target_y    <= target_y_next;
      delta_x     <= delta_x_next;
      neg_delta_y <= neg_delta_y_next;
      step_x_neg  <= step_x_neg_next;
      step_y_neg  <= step_y_neg_next;
      error_term  <= error_term_next;
      line_color  <= line_color_next;
      line_active <= line_active_next;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_fire) begin
      out_valid <= 1'b1;
    end else if (pix.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload; a step with no line gives all zeros
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      out_pixel_valid <= emit;
      out_offset      <= emit ? offset_calc : '0;
      out_keep        <= emit ? ~pixel_bit : '0;
      out_p0          <= (emit && line_color_next[0]) ? pixel_bit : '0;
      out_p1          <= (emit && line_color_next[1]) ? pixel_bit : '0;
      out_p2          <= (emit && line_color_next[2]) ? pixel_bit : '0;
      out_p3          <= (emit && line_color_next[3]) ? pixel_bit : '0;
      out_last        <= emit && is_last;
    end
  end

  assign pix.valid       = out_valid;
  assign pix.pixel_valid = out_pixel_valid;
  assign pix.byte_offset = out_offset;
  assign pix.keep_mask   = out_keep;
  assign pix.plane0_bits = out_p0;
  assign pix.plane1_bits = out_p1;
  assign pix.plane2_bits = out_p2;
  assign pix.plane3_bits = out_p3;
  assign pix.last_pixel  = out_last;

endmodule

/* hdl/pld_checker.sv */
// Port-level checks of the line drawer, bound to the top level.
// Depends on pld_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pld_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      cmd_valid,
  input logic                      cmd_ready,
  input logic                      cmd_mode,
  input logic                      pix_valid,
  input logic                      pix_ready,
  input logic                      pixel_valid,
  input logic [pld_pkg::OFF_W-1:0] byte_offset,
  input logic [7:0]                keep_mask,
  input logic [7:0]                plane0_bits,
  input logic [7:0]                plane3_bits,
  input logic                      last_pixel
);

  // Output register empties on reset
  `PLD_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !pix_valid, "pixel valid after reset")

  // A start transaction always yields a pixel write next cycle
  `PLD_ASSERT(a_start_pixel, clk, rst, (cmd_valid && cmd_ready && cmd_mode == pld_pkg::MODE_START) |=> (pix_valid && pixel_valid), "start gave no pixel")

  // Exactly one pixel bit is cleared by the keep mask, and planes 0 and 3 set only that bit
  `PLD_ASSERT(a_keep_onehot, clk, rst, (pix_valid && pixel_valid) |-> ($onehot(~keep_mask) && (plane0_bits & keep_mask) == 8'h00 && (plane3_bits & keep_mask) == 8'h00), "bad pixel masks")

  // An empty result carries zero fields
  `PLD_ASSERT(a_empty_zero, clk, rst, (pix_valid && !pixel_valid) |-> (byte_offset == '0 && keep_mask == 8'h00 && !last_pixel), "empty result not zero")

  // A stalled result holds
  `PLD_ASSERT(a_stall_hold, clk, rst, (pix_valid && !pix_ready) |=> (pix_valid && $stable(byte_offset) && $stable(keep_mask)), "stalled result changed")

endmodule

bind planar_line_drawer_unit pld_checker u_pld_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .cmd_mode    (cmd.mode),
  .pix_valid   (pix.valid),
  .pix_ready   (pix.ready),
  .pixel_valid (pix.pixel_valid),
  .byte_offset (pix.byte_offset),
  .keep_mask   (pix.keep_mask),
  .plane0_bits (pix.plane0_bits),
  .plane3_bits (pix.plane3_bits),
  .last_pixel  (pix.last_pixel)
);

/* tb/tb_planar_line_drawer_unit.sv */
// Self-checking testbench of planar_line_drawer_unit: start and step commands go in,
// and each pixel that comes out is checked against a cycle-free line predictor.
// Depends on pld_pkg, pld_cmd_if, pld_pixel_if and the unit itself.
`timescale 1ns / 1ps

module tb_planar_line_drawer_unit;

  localparam int X_W     = pld_pkg::X_W;
  localparam int Y_W     = pld_pkg::Y_W;
  localparam int COLOR_W = pld_pkg::COLOR_W;
  localparam int OFF_W   = pld_pkg::OFF_W;
  localparam int ERR_W   = pld_pkg::ERR_W;

  localparam int ROW_BYTES   = 30;
  localparam int RANDOM_CMDS = 700;
  localparam int HOLD_AT     = 150;   // result count that starts the long sink hold-off
  localparam int HOLD_LEN    = 80;
  localparam int PAUSE_AT    = 450;   // command count at which the source drains the unit
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;

  typedef struct packed {
    logic               mode;
    logic [X_W-1:0]     sx;
    logic [Y_W-1:0]     sy;
    logic [X_W-1:0]     ex;
    logic [Y_W-1:0]     ey;
    logic [COLOR_W-1:0] color;
  } line_cmd_t;

  typedef struct packed {
    logic             pixel_valid;
    logic [OFF_W-1:0] byte_offset;
    logic [7:0]       keep_mask;
    logic [7:0]       plane0_bits;
    logic [7:0]       plane1_bits;
    logic [7:0]       plane2_bits;
    logic [7:0]       plane3_bits;
    logic             last_pixel;
  } pixel_t;

  logic clk;
  logic rst;

  pld_cmd_if   cmd_bus ();
  pld_pixel_if pix_bus ();

  planar_line_drawer_unit #(
    .ROW_BYTES(ROW_BYTES)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_bus),
    .pix(pix_bus)
  );

  line_cmd_t pending_cmds[$];
  pixel_t    pixels_due[$];
  line_cmd_t on_bus;
  int        total_cmds;
  int        n_sent;
  int        n_got;
  int        errors;
  int        hold_left;
  int        quiet_cycles;

  // Predictor state: pen position, goal, slopes, error term and colour
  logic [X_W-1:0]            pen_x;
  logic [Y_W-1:0]            pen_y;
  logic [X_W-1:0]            goal_x;
  logic [Y_W-1:0]            goal_y;
  logic [X_W-1:0]            run_x;
  logic signed [X_W-1:0]     rise_neg;
  logic                      x_back;
  logic                      y_back;
  logic signed [ERR_W-1:0]   err_acc;
  logic [COLOR_W-1:0]        ink;
  logic                      drawing;

  // Next pixel of the line for one accepted command
  function automatic pixel_t predict_pixel(input line_cmd_t c);
    pixel_t     p;
    int         e2;
    int         err_next;
    int         dy_abs;
    int         off;
    logic [7:0] bit_sel;
    logic       last;
    p = '0;
    if (c.mode == pld_pkg::MODE_START) begin
      pen_x    = c.sx;
      pen_y    = c.sy;
      goal_x   = c.ex;
      goal_y   = c.ey;
      run_x    = (c.ex > c.sx) ? c.ex - c.sx : c.sx - c.ex;
      dy_abs   = (c.ey > c.sy) ? int'(c.ey) - int'(c.sy) : int'(c.sy) - int'(c.ey);
      rise_neg = X_W'(-dy_abs);
      x_back   = !(c.sx < c.ex);
      y_back   = !(c.sy < c.ey);
      err_acc  = ERR_W'(int'(run_x) + int'(rise_neg));
      ink      = c.color;
    end else begin
      // step with no line in progress: empty transaction, state kept
      if (!drawing) return p;
      e2       = 2 * int'(err_acc);
      err_next = int'(err_acc);
      if (e2 >= int'(rise_neg)) begin
        err_next = err_next + int'(rise_neg);
        pen_x    = x_back ? pen_x - 1'b1 : pen_x + 1'b1;
      end
      if (e2 <= int'(run_x)) begin
        err_next = err_next + int'(run_x);
        pen_y    = y_back ? pen_y - 1'b1 : pen_y + 1'b1;
      end
      err_acc = ERR_W'(err_next);
    end
    last    = (pen_x == goal_x) && (pen_y == goal_y);
    drawing = !last;
    bit_sel = pld_pkg::PIXEL_MSB >> pen_x[2:0];
    off     = int'(pen_y) * 4 * ROW_BYTES + int'(pen_x >> 3);
    p.pixel_valid = 1'b1;
    p.byte_offset = OFF_W'(off);
    p.keep_mask   = ~bit_sel;
    p.plane0_bits = ink[0] ? bit_sel : 8'h00;
    p.plane1_bits = ink[1] ? bit_sel : 8'h00;
    p.plane2_bits = ink[2] ? bit_sel : 8'h00;
    p.plane3_bits = ink[3] ? bit_sel : 8'h00;
    p.last_pixel  = last;
    return p;
  endfunction

  // Idle percentage of either side for the current third of the run
  function automatic int idle_pct(input logic sender);
    int ph;
    ph = (total_cmds == 0) ? 0 : n_sent * 3 / total_cmds;
    case (ph)
      0:       idle_pct = sender ? 35 : 51;
      1:       idle_pct = sender ? 51 : 35;
      default: idle_pct = 0;
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h", n_got, what, got, want);
  endtask

  task automatic push_cmd(input logic mode, input int sx, input int sy, input int ex,
                          input int ey, input int color);
    line_cmd_t c;
    c.mode  = mode;
    c.sx    = X_W'(sx);
    c.sy    = Y_W'(sy);
    c.ex    = X_W'(ex);
    c.ey    = Y_W'(ey);
    c.color = COLOR_W'(color);
    pending_cmds.push_back(c);
  endtask

  // Step commands carry random endpoint fields, which the unit must ignore
  task automatic push_steps(input int n);
    for (int i = 0; i < n; i++)
      push_cmd(pld_pkg::MODE_STEP, $urandom_range(0, 255), $urandom_range(0, 127),
               $urandom_range(0, 255), $urandom_range(0, 127), $urandom_range(0, 15));
  endtask

  // Random line: mostly short, now and then across the frame; steps are exact,
  // run past the end, or stop early so the next start abandons the line
  task automatic push_random_line();
    int sx, sy, ex, ey, w, n, v;
    sx = $urandom_range(0, 255);
    sy = $urandom_range(0, 127);
    if ($urandom_range(0, 99) < 3) begin
      ex = $urandom_range(0, 255);
      ey = $urandom_range(0, 127);
    end else begin
      w  = $urandom_range(0, 12);
      ex = sx + $urandom_range(0, 2 * w) - w;
      ey = sy + $urandom_range(0, 2 * w) - w;
      ex = (ex < 0) ? 0 : (ex > 255) ? 255 : ex;
      ey = (ey < 0) ? 0 : (ey > 127) ? 127 : ey;
    end
    n = (ex > sx ? ex - sx : sx - ex);
    if ((ey > sy ? ey - sy : sy - ey) > n) n = (ey > sy ? ey - sy : sy - ey);
    v = $urandom_range(0, 99);
    if (v >= 85)      n = n + $urandom_range(1, 3);
    else if (v >= 70) n = (n == 0) ? 0 : $urandom_range(0, n - 1);
    push_cmd(pld_pkg::MODE_START, sx, sy, ex, ey, $urandom_range(0, 15));
    push_steps(n);
  endtask

  // Clock and the single reset pulse
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cmd_bus.valid     = 1'b0;
    cmd_bus.mode      = pld_pkg::MODE_START;
    cmd_bus.start_x   = '0;
    cmd_bus.start_y   = '0;
    cmd_bus.end_x     = '0;
    cmd_bus.end_y     = '0;
    cmd_bus.pen_color = '0;
    pix_bus.ready     = 1'b0;
    fork
      forever #2 clk = ~clk;
      begin
        repeat (6) @(posedge clk);
        rst <= 1'b0;
      end
    join_none
  end

  // Command driver: one transaction per handshake, random gaps, one drain pause
  always @(posedge clk) begin
    logic offer;
    if (rst) begin
      cmd_bus.valid <= 1'b0;
    end else begin
      offer = cmd_bus.valid;
      if (cmd_bus.valid && cmd_bus.ready) begin
        pixels_due.push_back(predict_pixel(on_bus));
        n_sent++;
        offer = 1'b0;
      end
      if (!offer) begin
        if (pending_cmds.size() != 0 && !(n_sent == PAUSE_AT && pixels_due.size() != 0)
            && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
          on_bus = pending_cmds.pop_front();
          cmd_bus.valid     <= 1'b1;
          cmd_bus.mode      <= on_bus.mode;
          cmd_bus.start_x   <= on_bus.sx;
          cmd_bus.start_y   <= on_bus.sy;
          cmd_bus.end_x     <= on_bus.ex;
          cmd_bus.end_y     <= on_bus.ey;
          cmd_bus.pen_color <= on_bus.color;
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Pixel monitor: checks each transaction against the oldest prediction
  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      pix_bus.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (pix_bus.valid && pix_bus.ready) begin
        if (pixels_due.size() == 0) begin
          flag_mismatch("pixel with nothing expected", 1, 0);
        end else begin
          want = pixels_due.pop_front();
          if (pix_bus.pixel_valid !== want.pixel_valid)
            flag_mismatch("pixel_valid", pix_bus.pixel_valid, want.pixel_valid);
          if (pix_bus.byte_offset !== want.byte_offset)
            flag_mismatch("byte_offset", pix_bus.byte_offset, want.byte_offset);
          if (pix_bus.keep_mask !== want.keep_mask)
            flag_mismatch("keep_mask", pix_bus.keep_mask, want.keep_mask);
          if (pix_bus.plane0_bits !== want.plane0_bits)
            flag_mismatch("plane0_bits", pix_bus.plane0_bits, want.plane0_bits);
          if (pix_bus.plane1_bits !== want.plane1_bits)
            flag_mismatch("plane1_bits", pix_bus.plane1_bits, want.plane1_bits);
          if (pix_bus.plane2_bits !== want.plane2_bits)
            flag_mismatch("plane2_bits", pix_bus.plane2_bits, want.plane2_bits);
          if (pix_bus.plane3_bits !== want.plane3_bits)
            flag_mismatch("plane3_bits", pix_bus.plane3_bits, want.plane3_bits);
          if (pix_bus.last_pixel !== want.last_pixel)
            flag_mismatch("last_pixel", pix_bus.last_pixel, want.last_pixel);
        end
        n_got++;
        if (n_got == HOLD_AT) hold_left = HOLD_LEN;
      end
      // long hold-off lets the unit fill up and stall its command side
      if (hold_left > 0) begin
        hold_left--;
        pix_bus.ready <= 1'b0;
      end else begin
        pix_bus.ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if ((cmd_bus.valid && cmd_bus.ready) || (pix_bus.valid && pix_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    n_sent = 0;
    n_got  = 0;
    errors = 0;

    // predictor starts as the unit does out of reset: no line in progress
    pen_x    = '0;
    pen_y    = '0;
    goal_x   = '0;
    goal_y   = '0;
    run_x    = '0;
    rise_neg = '0;
    x_back   = 1'b0;
    y_back   = 1'b0;
    err_acc  = '0;
    ink      = '0;
    drawing  = 1'b0;

    // step straight after reset: no line in progress
    push_steps(1);
    // single-pixel lines at both corners, with a step past the end after the first
    push_cmd(pld_pkg::MODE_START, 0, 0, 0, 0, 0);
    push_steps(1);
    push_cmd(pld_pkg::MODE_START, 255, 127, 255, 127, 15);
    // shallow line up and to the right
    push_cmd(pld_pkg::MODE_START, 3, 5, 7, 2, 5);
    push_steps(4);
    // line abandoned by a new start part way through
    push_cmd(pld_pkg::MODE_START, 250, 120, 240, 127, 10);
    push_steps(2);
    // steep line, then one step beyond the end
    push_cmd(pld_pkg::MODE_START, 0, 127, 1, 124, 9);
    push_steps(4);
    // pure horizontal leftwards and pure vertical downwards
    push_cmd(pld_pkg::MODE_START, 100, 10, 98, 10, 6);
    push_steps(2);
    push_cmd(pld_pkg::MODE_START, 8, 0, 8, 2, 3);
    push_steps(2);

    // random part: mostly well-formed lines, some noise
    while (pending_cmds.size() < RANDOM_CMDS + 24) begin
      if ($urandom_range(0, 99) < 10)
        push_cmd($urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 127),
                 $urandom_range(0, 255), $urandom_range(0, 127), $urandom_range(0, 15));
      else
        push_random_line();
    end
    total_cmds = pending_cmds.size();

    while (n_sent < total_cmds) @(posedge clk);
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pixels_due.size() != 0)
      flag_mismatch("pixels never delivered", pixels_due.size(), 0);

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* planar_line_drawer_unit.f */
+incdir+hdl
hdl/pld_pkg.sv
hdl/pld_cmd_if.sv
hdl/pld_pixel_if.sv
hdl/planar_line_drawer_unit.sv
hdl/pld_checker.sv
tb/tb_planar_line_drawer_unit.sv
